FILE: design/ir_proximity_distance_nearest_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the proximity distance block
// Shared property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef IR_PROXIMITY_DISTANCE_NEAREST_ASSERT_SVH
`define IR_PROXIMITY_DISTANCE_NEAREST_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define IPDN_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ipdn check failed in %m");

// Next-cycle implication, switched off while reset is held.
`define IPDN_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ipdn check failed in %m");

`endif

FILE: design/ipdn_pkg.sv
// ---------------------------------------------------------------------------
// ipdn_pkg
// Constants, types and the divider step shared by the distance block.
// ---------------------------------------------------------------------------
package ipdn_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int IDX_W        = $clog2(SENSOR_COUNT);

    localparam int READING_W  = 16;
    localparam int PROX_W     = 15;
    localparam int LIMIT_W    = 8;
    localparam int SCALE_W    = 16;
    localparam int OFFSET_W   = 24;
    localparam int DIST_W     = 8;
    localparam int NEAREST_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Q16 reciprocal: only quotients below 2^(DIST_W+FRAC_W) can give a
    // distance under saturation, so the divider produces just those bits.
    localparam int FRAC_W      = 16;
    localparam int QUO_W       = DIST_W + FRAC_W;
    localparam int HEAD_SHIFT  = QUO_W - FRAC_W;
    localparam int DIV_W       = PROX_W;
    localparam int STEP_BITS   = 4;
    localparam int DIV_STAGES  = QUO_W / STEP_BITS;
    localparam int LANE_STAGES = DIV_STAGES + 2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [PROX_W-1:0]   PROX_LOW_RST   = PROX_W'(100);
    localparam logic [PROX_W-1:0]   PROX_HIGH_RST  = PROX_W'(10000);
    localparam logic [LIMIT_W-1:0]  NEAR_LIMIT_RST = LIMIT_W'(40);
    localparam logic [SCALE_W-1:0]  SCALE_RST      = SCALE_W'(5779);
    localparam logic [OFFSET_W-1:0] OFFSET_RST     = OFFSET_W'(206898);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROX_LOW   = 3'd0,
        CFG_PROX_HIGH  = 3'd1,
        CFG_NEAR_LIMIT = 3'd2,
        CFG_SCALE      = 3'd3,
        CFG_OFFSET     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PROX_W-1:0]   prox_low;
        logic [PROX_W-1:0]   prox_high;
        logic [SCALE_W-1:0]  scale;
        logic [OFFSET_W-1:0] offset;
    } t_lane_cfg;

    typedef struct packed {
        logic [LANE_STAGES-1:0] load;
        logic                   out_load;
    } t_pipe_ctl;

    typedef struct packed {
        logic             q;
        logic [DIV_W-1:0] rem;
    } t_div_step;

    // One restoring division step: bring down one dividend bit and subtract
    // the divisor where it fits.
    function automatic t_div_step div_step(input logic [DIV_W-1:0] rem,
                                           input logic             nbit,
                                           input logic [DIV_W-1:0] dv);
        logic [DIV_W:0] trial;
        t_div_step      res;
        trial = {rem, nbit};
        if (trial >= {1'b0, dv}) begin
            res.q   = 1'b1;
            res.rem = DIV_W'(trial - {1'b0, dv});
        end else begin
            res.q   = 1'b0;
            res.rem = trial[DIV_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: design/ipdn_ctrl.sv
// ---------------------------------------------------------------------------
// ipdn_ctrl
// Valid tracking and stage enables for the lane pipeline and output register.
// ---------------------------------------------------------------------------
module ipdn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ipdn_pkg::t_pipe_ctl o_ctl
);
    import ipdn_pkg::*;

    logic [LANE_STAGES-1:0] r_valid;
    logic [LANE_STAGES-1:0] n_valid;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [LANE_STAGES:0]   en;

    // A stage moves on when it is empty or when the stage after it moves on,
    // so bubbles close up while a result waits at the output.
    always_comb begin
        en[LANE_STAGES] = !r_out_valid || i_out_ready;
        for (int k = LANE_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    always_comb begin
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        if (en[0]) begin
            n_valid[0] = i_in_valid;
        end
        for (int k = 1; k < LANE_STAGES; k++) begin
            if (en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
        if (en[LANE_STAGES]) begin
            n_out_valid = r_valid[LANE_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ctl.load     = en[LANE_STAGES-1:0];
    assign o_ctl.out_load = en[LANE_STAGES];
    assign o_in_ready     = en[0];
    assign o_out_valid    = r_out_valid;

endmodule

FILE: design/ipdn_lane.sv
// ---------------------------------------------------------------------------
// ipdn_lane
// One sensor lane: window check, pipelined Q16 reciprocal, offset and clamp.
// ---------------------------------------------------------------------------
module ipdn_lane (
    input  logic                                 i_clk,
    input  ipdn_pkg::t_pipe_ctl                  i_ctl,
    input  ipdn_pkg::t_lane_cfg                  i_cfg,
    input  logic signed [ipdn_pkg::READING_W-1:0] i_reading,
    output logic [ipdn_pkg::DIST_W-1:0]          o_dist
);
    import ipdn_pkg::*;

    logic             r_sat [0:DIV_STAGES];
    logic [DIV_W-1:0] r_div [0:DIV_STAGES];
    logic [DIV_W-1:0] r_rem [0:DIV_STAGES];
    logic [QUO_W-1:0] r_num [0:DIV_STAGES];
    logic [QUO_W-1:0] r_quo [0:DIV_STAGES];
    logic [DIST_W-1:0] r_dist;

    logic             in_win;
    logic             n_sat0;
    logic [DIV_W-1:0] c_rem [1:DIV_STAGES];
    logic [QUO_W-1:0] c_num [1:DIV_STAGES];
    logic [QUO_W-1:0] c_quo [1:DIV_STAGES];

    logic [QUO_W:0]    sum;
    logic [DIST_W:0]   whole;
    logic [DIST_W-1:0] n_dist;

    // The window bounds are non-negative, so a reading inside it is positive
    // and its low bits are a non-zero divisor.
    assign in_win = !i_reading[READING_W-1]
                 && (i_reading[PROX_W-1:0] > i_cfg.prox_low)
                 && (i_reading[PROX_W-1:0] < i_cfg.prox_high);

    // The quotient reaches 2^QUO_W exactly when the top dividend bits already
    // hold the divisor; such a distance saturates anyway.
    assign n_sat0 = !in_win
                 || (DIV_W'(i_cfg.scale >> HEAD_SHIFT) >= i_reading[PROX_W-1:0]);

    always_comb begin
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] num;
        logic [QUO_W-1:0] quo;
        t_div_step        step;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            rem = r_rem[k-1];
            num = r_num[k-1];
            quo = r_quo[k-1];
            for (int b = 0; b < STEP_BITS; b++) begin
                step = div_step(rem, num[QUO_W-1], r_div[k-1]);
                rem  = step.rem;
                quo  = {quo[QUO_W-2:0], step.q};
                num  = {num[QUO_W-2:0], 1'b0};
            end
            c_rem[k] = rem;
            c_num[k] = num;
            c_quo[k] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r_sat[0] <= n_sat0;
            r_div[0] <= i_reading[PROX_W-1:0];
            r_rem[0] <= DIV_W'(i_cfg.scale >> HEAD_SHIFT);
            r_num[0] <= {i_cfg.scale[HEAD_SHIFT-1:0], {FRAC_W{1'b0}}};
            r_quo[0] <= '0;
        end
        for (int k = 1; k <= DIV_STAGES; k++) begin
            if (i_ctl.load[k]) begin
                r_sat[k] <= r_sat[k-1];
                r_div[k] <= r_div[k-1];
                r_rem[k] <= c_rem[k];
                r_num[k] <= c_num[k];
                r_quo[k] <= c_quo[k];
            end
        end
        if (i_ctl.load[LANE_STAGES-1]) begin
            r_dist <= n_dist;
        end
    end

    assign sum    = {1'b0, r_quo[DIV_STAGES]} + (QUO_W + 1)'(i_cfg.offset);
    assign whole  = sum[QUO_W:FRAC_W];
    assign n_dist = (r_sat[DIV_STAGES] || whole[DIST_W]) ? DIST_MAX : whole[DIST_W-1:0];
    assign o_dist = r_dist;

endmodule

FILE: design/ipdn_merge.sv
// ---------------------------------------------------------------------------
// ipdn_merge
// Registered minimum tree over the lane distances, with the near flag.
// ---------------------------------------------------------------------------
module ipdn_merge (
    input  logic                          i_clk,
    input  ipdn_pkg::t_pipe_ctl           i_ctl,
    input  logic [ipdn_pkg::LIMIT_W-1:0]  i_near_limit,
    input  logic [ipdn_pkg::DIST_W-1:0]   i_dist [ipdn_pkg::SENSOR_COUNT],
    output logic [ipdn_pkg::DIST_W-1:0]   o_dist [ipdn_pkg::SENSOR_COUNT],
    output logic [ipdn_pkg::NEAREST_W-1:0] o_nearest_index,
    output logic                          o_near_flag
);
    import ipdn_pkg::*;

    localparam int LVL = (IDX_W < 1) ? 1 : IDX_W;
    localparam int PAD = 1 << LVL;

    logic [DIST_W-1:0] lv_d [0:LVL][0:PAD-1];
    logic [IDX_W-1:0]  lv_i [0:LVL][0:PAD-1];

    logic [DIST_W-1:0] r_dist [SENSOR_COUNT];
    logic [IDX_W-1:0]  r_idx;
    logic              r_near;

    // Unused leaves carry the maximum and a higher index, so a real lane
    // always wins against them. On equal distances the left (lower) side wins.
    always_comb begin
        for (int l = 0; l <= LVL; l++) begin
            for (int j = 0; j < PAD; j++) begin
                lv_d[l][j] = DIST_MAX;
                lv_i[l][j] = '0;
            end
        end
        for (int j = 0; j < PAD; j++) begin
            lv_i[0][j] = IDX_W'(j);
            if (j < SENSOR_COUNT) begin
                lv_d[0][j] = i_dist[j];
            end
        end
        for (int l = 0; l < LVL; l++) begin
            for (int j = 0; j < (PAD >> (l + 1)); j++) begin
                if (lv_d[l][2*j+1] < lv_d[l][2*j]) begin
                    lv_d[l+1][j] = lv_d[l][2*j+1];
                    lv_i[l+1][j] = lv_i[l][2*j+1];
                end else begin
                    lv_d[l+1][j] = lv_d[l][2*j];
                    lv_i[l+1][j] = lv_i[l][2*j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_dist <= i_dist;
            r_idx  <= lv_i[LVL][0];
            r_near <= (lv_d[LVL][0] < i_near_limit);
        end
    end

    assign o_dist          = r_dist;
    assign o_nearest_index = NEAREST_W'(r_idx);
    assign o_near_flag     = r_near;

endmodule

FILE: design/ir_proximity_distance_nearest.sv
// ---------------------------------------------------------------------------
// ir_proximity_distance_nearest
// Eight infrared proximity readings to distances, with nearest-obstacle pick.
// ---------------------------------------------------------------------------
// A frame of eight readings is taken whenever i_in_valid and o_in_ready are
// both high, and one frame can be taken every clock cycle until a stalled
// output has backed the pipeline up. Its result word passes through a
// window check stage, the per-lane reciprocal divider stages (four quotient
// bits per stage, 24 bits in all), an offset and clamp stage, and the output
// register that holds the minimum search. A stalled output only holds back
// the frames behind it once the empty pipeline stages have filled.
// Configuration writes are always accepted (o_cfg_ready stays high)
// and must only be issued while no frame is in flight.
module ir_proximity_distance_nearest (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ipdn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ipdn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [ipdn_pkg::READING_W-1:0] i_reading_0,
    input  logic signed [ipdn_pkg::READING_W-1:0] i_reading_1,
    input  logic signed [ipdn_pkg::READING_W-1:0] i_reading_2,
    input  logic signed [ipdn_pkg::READING_W-1:0] i_reading_3,
    input  logic signed [ipdn_pkg::READING_W-1:0] i_reading_4,
    input  logic signed [ipdn_pkg::READING_W-1:0] i_reading_5,
    input  logic signed [ipdn_pkg::READING_W-1:0] i_reading_6,
    input  logic signed [ipdn_pkg::READING_W-1:0] i_reading_7,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ipdn_pkg::DIST_W-1:0]         o_dist_0,
    output logic [ipdn_pkg::DIST_W-1:0]         o_dist_1,
    output logic [ipdn_pkg::DIST_W-1:0]         o_dist_2,
    output logic [ipdn_pkg::DIST_W-1:0]         o_dist_3,
    output logic [ipdn_pkg::DIST_W-1:0]         o_dist_4,
    output logic [ipdn_pkg::DIST_W-1:0]         o_dist_5,
    output logic [ipdn_pkg::DIST_W-1:0]         o_dist_6,
    output logic [ipdn_pkg::DIST_W-1:0]         o_dist_7,
    output logic [ipdn_pkg::NEAREST_W-1:0]      o_nearest_index,
    output logic                                o_near_flag
);
    import ipdn_pkg::*;

    logic [PROX_W-1:0]   r_prox_low;
    logic [PROX_W-1:0]   r_prox_high;
    logic [LIMIT_W-1:0]  r_near_limit;
    logic [SCALE_W-1:0]  r_scale;
    logic [OFFSET_W-1:0] r_offset;

    t_lane_cfg lane_cfg;
    t_pipe_ctl ctl;

    logic signed [READING_W-1:0] reading [SENSOR_COUNT];
    logic [DIST_W-1:0]           lane_dist [SENSOR_COUNT];
    logic [DIST_W-1:0]           out_dist [SENSOR_COUNT];

    assign o_cfg_ready = 1'b1;

    // Unknown register indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prox_low   <= PROX_LOW_RST;
            r_prox_high  <= PROX_HIGH_RST;
            r_near_limit <= NEAR_LIMIT_RST;
            r_scale      <= SCALE_RST;
            r_offset     <= OFFSET_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROX_LOW: begin
                    r_prox_low <= i_cfg_data[PROX_W-1:0];
                end
                CFG_PROX_HIGH: begin
                    r_prox_high <= i_cfg_data[PROX_W-1:0];
                end
                CFG_NEAR_LIMIT: begin
                    r_near_limit <= i_cfg_data[LIMIT_W-1:0];
                end
                CFG_SCALE: begin
                    r_scale <= i_cfg_data[SCALE_W-1:0];
                end
                CFG_OFFSET: begin
                    r_offset <= i_cfg_data[OFFSET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign lane_cfg.prox_low  = r_prox_low;
    assign lane_cfg.prox_high = r_prox_high;
    assign lane_cfg.scale     = r_scale;
    assign lane_cfg.offset    = r_offset;

    assign reading[0] = i_reading_0;
    assign reading[1] = i_reading_1;
    assign reading[2] = i_reading_2;
    assign reading[3] = i_reading_3;
    assign reading[4] = i_reading_4;
    assign reading[5] = i_reading_5;
    assign reading[6] = i_reading_6;
    assign reading[7] = i_reading_7;

    ipdn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        ipdn_lane u_lane (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_cfg     (lane_cfg),
            .i_reading (reading[g]),
            .o_dist    (lane_dist[g])
        );
    end

    ipdn_merge u_merge (
        .i_clk           (i_clk),
        .i_ctl           (ctl),
        .i_near_limit    (r_near_limit),
        .i_dist          (lane_dist),
        .o_dist          (out_dist),
        .o_nearest_index (o_nearest_index),
        .o_near_flag     (o_near_flag)
    );

    assign o_dist_0 = out_dist[0];
    assign o_dist_1 = out_dist[1];
    assign o_dist_2 = out_dist[2];
    assign o_dist_3 = out_dist[3];
    assign o_dist_4 = out_dist[4];
    assign o_dist_5 = out_dist[5];
    assign o_dist_6 = out_dist[6];
    assign o_dist_7 = out_dist[7];

endmodule

FILE: design/ipdn_checker.sv
// ---------------------------------------------------------------------------
// ipdn_checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "ir_proximity_distance_nearest_assert.svh"

module ipdn_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [ipdn_pkg::DIST_W-1:0]         o_dist_0,
    input logic [ipdn_pkg::DIST_W-1:0]         o_dist_1,
    input logic [ipdn_pkg::DIST_W-1:0]         o_dist_2,
    input logic [ipdn_pkg::DIST_W-1:0]         o_dist_3,
    input logic [ipdn_pkg::DIST_W-1:0]         o_dist_4,
    input logic [ipdn_pkg::DIST_W-1:0]         o_dist_5,
    input logic [ipdn_pkg::DIST_W-1:0]         o_dist_6,
    input logic [ipdn_pkg::DIST_W-1:0]         o_dist_7,
    input logic [ipdn_pkg::NEAREST_W-1:0]      o_nearest_index,
    input logic                                o_near_flag
);
    import ipdn_pkg::*;

    // A word offered and not taken is still offered next cycle.
    `IPDN_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // Such a held word keeps dist_0, dist_7, the index and the flag unchanged.
    `IPDN_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_dist_0) && $stable(o_dist_7) && $stable(o_nearest_index) && $stable(o_near_flag))

    // The first sensor is chosen only when nothing else is strictly nearer.
    `IPDN_ASSERT_IMP(a_pick_first, i_clk, i_rst_n, o_out_valid && (o_nearest_index == 3'd0), (o_dist_0 <= o_dist_1) && (o_dist_0 <= o_dist_2) && (o_dist_0 <= o_dist_3) && (o_dist_0 <= o_dist_4) && (o_dist_0 <= o_dist_5) && (o_dist_0 <= o_dist_6) && (o_dist_0 <= o_dist_7))

    // The last sensor wins only when it is strictly nearer than every other.
    `IPDN_ASSERT_IMP(a_pick_last, i_clk, i_rst_n, o_out_valid && (o_nearest_index == 3'd7), (o_dist_7 < o_dist_0) && (o_dist_7 < o_dist_1) && (o_dist_7 < o_dist_2) && (o_dist_7 < o_dist_3) && (o_dist_7 < o_dist_4) && (o_dist_7 < o_dist_5) && (o_dist_7 < o_dist_6))

endmodule

bind ir_proximity_distance_nearest ipdn_checker u_ipdn_checker (.*);

FILE: bench/ir_proximity_distance_nearest_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Proximity distance checker
// Watches the configuration, frame and result channels of the distance block,
// keeps its own copy of the registers, predicts every result word from the
// accepted readings and compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module ir_proximity_distance_nearest_checker (
    input  logic                                                        i_clk,
    input  logic                                                        i_rst_n,
    input  logic                                                        i_cfg_valid,
    input  logic                                                        i_cfg_ready,
    input  logic [ipdn_pkg::CFG_IDX_W-1:0]                              i_cfg_index,
    input  logic [ipdn_pkg::CFG_DATA_W-1:0]                             i_cfg_data,
    input  logic                                                        i_in_valid,
    input  logic                                                        i_in_ready,
    input  logic [ipdn_pkg::SENSOR_COUNT-1:0][ipdn_pkg::READING_W-1:0]  i_readings,
    input  logic                                                        i_out_valid,
    input  logic                                                        i_out_ready,
    input  logic [ipdn_pkg::SENSOR_COUNT-1:0][ipdn_pkg::DIST_W-1:0]     i_dists,
    input  logic [ipdn_pkg::NEAREST_W-1:0]                              i_nearest_index,
    input  logic                                                        i_near_flag,
    output int                                                          o_pending,
    output int                                                          o_fail_count
);
    import ipdn_pkg::*;

    typedef struct packed {
        logic [SENSOR_COUNT-1:0][DIST_W-1:0] dists;
        logic [NEAREST_W-1:0]                nearest;
        logic                                flag;
    } t_frame_result;

    logic [PROX_W-1:0]   win_low;
    logic [PROX_W-1:0]   win_high;
    logic [LIMIT_W-1:0]  near_limit;
    logic [SCALE_W-1:0]  recip_scale;
    logic [OFFSET_W-1:0] dist_offset;

    t_frame_result expected_frames[$];

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    // Window test is signed, so only positive readings can ever be divided.
    function automatic logic [DIST_W-1:0] reading_to_distance(input logic [READING_W-1:0] rd);
        int          sr;
        logic [63:0] quo;
        sr = $signed(rd);
        if (!(sr > int'(win_low) && sr < int'(win_high)))
            return DIST_MAX;
        quo = {32'd0, recip_scale, 16'd0} / 64'(sr);
        quo = (quo + 64'(dist_offset)) >> FRAC_W;
        return (quo > 64'(DIST_MAX)) ? DIST_MAX : quo[DIST_W-1:0];
    endfunction

    function automatic t_frame_result predict_frame(
        input logic [SENSOR_COUNT-1:0][READING_W-1:0] rds);
        t_frame_result     res;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] best;
        best        = '0;
        res.nearest = '0;
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            d            = reading_to_distance(rds[k]);
            res.dists[k] = d;
            // Strict comparison keeps the first lane on ties.
            if (k == 0 || d < best) begin
                best        = d;
                res.nearest = NEAREST_W'(k);
            end
        end
        res.flag = (best < near_limit);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            win_low     = PROX_LOW_RST;
            win_high    = PROX_HIGH_RST;
            near_limit  = NEAR_LIMIT_RST;
            recip_scale = SCALE_RST;
            dist_offset = OFFSET_RST;
            expected_frames.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROX_LOW:   win_low     = i_cfg_data[PROX_W-1:0];
                    CFG_PROX_HIGH:  win_high    = i_cfg_data[PROX_W-1:0];
                    CFG_NEAR_LIMIT: near_limit  = i_cfg_data[LIMIT_W-1:0];
                    CFG_SCALE:      recip_scale = i_cfg_data[SCALE_W-1:0];
                    CFG_OFFSET:     dist_offset = i_cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_frames.push_back(predict_frame(i_readings));
            if (i_out_valid && i_out_ready) begin
                if (expected_frames.size() == 0) begin
                    $error("result word arrived with no frame outstanding");
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_frames.pop_front();
                    for (int k = 0; k < SENSOR_COUNT; k++) begin
                        if (i_dists[k] !== want.dists[k]) begin
                            $error("dist_%0d mismatch: expected %0d, actual %0d",
                                   k, want.dists[k], i_dists[k]);
                            o_fail_count = o_fail_count + 1;
                        end
                    end
                    if (i_nearest_index !== want.nearest) begin
                        $error("nearest_index mismatch: expected %0d, actual %0d",
                               want.nearest, i_nearest_index);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_near_flag !== want.flag) begin
                        $error("near_flag mismatch: expected %0d, actual %0d",
                               want.flag, i_near_flag);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_frames.size();
    end

endmodule

FILE: bench/ir_proximity_distance_nearest_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Proximity distance testbench
// Drives frames of eight readings through the distance block under several
// register settings, with bursty input traffic and a stalling receiver, and
// leaves prediction and comparison to the checker beside the block.
// ---------------------------------------------------------------------------
module ir_proximity_distance_nearest_tb;
    import ipdn_pkg::*;

    typedef logic [SENSOR_COUNT-1:0][READING_W-1:0] t_readings;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MASK} t_rx_pattern;

    localparam int  RX_HOLD_CYCLES = 80;
    localparam int  HOLD_BURST     = 48;
    localparam int  RANDOM_PHASES  = 5;
    localparam int  DRAIN_CYCLES   = 16;
    localparam real TIMEOUT_NS     = 1000000.0;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_OFFSET + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_readings             i_readings;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [DIST_W-1:0]     o_dist_0, o_dist_1, o_dist_2, o_dist_3;
    logic [DIST_W-1:0]     o_dist_4, o_dist_5, o_dist_6, o_dist_7;
    logic [NEAREST_W-1:0]  o_nearest_index;
    logic                  o_near_flag;

    int   frames_pending;
    int   fail_count;
    logic rx_hold_req = 1'b0;
    int   win_low_now;
    int   win_high_now;

    ir_proximity_distance_nearest dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_reading_0     (i_readings[0]),
        .i_reading_1     (i_readings[1]),
        .i_reading_2     (i_readings[2]),
        .i_reading_3     (i_readings[3]),
        .i_reading_4     (i_readings[4]),
        .i_reading_5     (i_readings[5]),
        .i_reading_6     (i_readings[6]),
        .i_reading_7     (i_readings[7]),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_dist_0        (o_dist_0),
        .o_dist_1        (o_dist_1),
        .o_dist_2        (o_dist_2),
        .o_dist_3        (o_dist_3),
        .o_dist_4        (o_dist_4),
        .o_dist_5        (o_dist_5),
        .o_dist_6        (o_dist_6),
        .o_dist_7        (o_dist_7),
        .o_nearest_index (o_nearest_index),
        .o_near_flag     (o_near_flag)
    );

    ir_proximity_distance_nearest_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_readings      (i_readings),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_dists         ({o_dist_7, o_dist_6, o_dist_5, o_dist_4,
                           o_dist_3, o_dist_2, o_dist_1, o_dist_0}),
        .i_nearest_index (o_nearest_index),
        .i_near_flag     (o_near_flag),
        .o_pending       (frames_pending),
        .o_fail_count    (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL ir_proximity_distance_nearest");
        $finish;
    end

    // Receiver: picks a new stall pattern whenever its randomly drawn run ends, and
    // on request holds off completely so that the pipeline backs up.
    initial begin
        t_rx_pattern pattern;
        int          left;
        logic [7:0]  mask;
        pattern     = RX_OPEN;
        left        = 0;
        mask        = '0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_ready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            if (left == 0) begin
                pattern = t_rx_pattern'($urandom_range(RX_OPEN, RX_MASK));
                left    = $urandom_range(8, 64);
                mask    = $urandom();
            end
            left = left - 1;
            case (pattern)
                RX_OPEN:   i_out_ready = 1'b1;
                RX_COIN:   i_out_ready = $urandom_range(0, 1);
                RX_SPARSE: i_out_ready = ($urandom_range(0, 3) == 0);
                default: begin
                    i_out_ready = mask[0];
                    mask        = {mask[0], mask[7:1]};
                end
            endcase
        end
    end

    // All driving tasks start and end just after a falling edge.
    task automatic send_frame(input t_readings f);
        logic taken;
        i_readings = f;
        i_in_valid = 1'b1;
        do begin
            @(posedge i_clk);
            taken = o_in_ready;
            @(negedge i_clk);
        end while (!taken);
    endtask

    task automatic idle_sender(input int cycles);
        i_in_valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (frames_pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        logic taken;
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do begin
            @(posedge i_clk);
            taken = o_cfg_ready;
            @(negedge i_clk);
        end while (!taken);
        i_cfg_valid = 1'b0;
        // Keep a copy of the window so that readings can be aimed inside it.
        if (idx == CFG_PROX_LOW)
            win_low_now = int'(data[PROX_W-1:0]);
        else if (idx == CFG_PROX_HIGH)
            win_high_now = int'(data[PROX_W-1:0]);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] low, input logic [CFG_DATA_W-1:0] high,
                              input logic [CFG_DATA_W-1:0] limit,
                              input logic [CFG_DATA_W-1:0] scale,
                              input logic [CFG_DATA_W-1:0] offset);
        write_reg(CFG_PROX_LOW, low);
        write_reg(CFG_PROX_HIGH, high);
        write_reg(CFG_NEAR_LIMIT, limit);
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_OFFSET, offset);
    endtask

    function automatic logic [READING_W-1:0] random_reading();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel < 8 && win_high_now - win_low_now >= 2)
            return READING_W'($urandom_range(win_low_now + 1, win_high_now - 1));
        case (sel)
            8: begin
                case ($urandom_range(0, 3))
                    0:       return READING_W'(win_low_now);
                    1:       return READING_W'(win_low_now + 1);
                    2:       return READING_W'(win_high_now - 1);
                    default: return READING_W'(win_high_now);
                endcase
            end
            9:  return READING_W'($urandom_range(1, 64));
            10: return READING_W'(32'd0 - $urandom_range(1, 32768));
            11: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h0000;
                    1:       return 16'h8000;
                    2:       return 16'h7FFF;
                    default: return 16'hFFFF;
                endcase
            end
            default: return READING_W'($urandom());
        endcase
    endfunction

    // Repeated readings within a frame give ties for the nearest pick.
    function automatic t_readings random_frame();
        t_readings f;
        int        src;
        if ($urandom_range(0, 19) == 0) begin
            f[0] = random_reading();
            for (int k = 1; k < SENSOR_COUNT; k++)
                f[k] = f[0];
        end else begin
            for (int k = 0; k < SENSOR_COUNT; k++) begin
                if (k > 0 && $urandom_range(0, 5) == 0) begin
                    src  = $urandom_range(0, k - 1);
                    f[k] = f[src];
                end else begin
                    f[k] = random_reading();
                end
            end
        end
        return f;
    endfunction

    function automatic t_readings uniform_frame(input logic [READING_W-1:0] v);
        t_readings f;
        for (int k = 0; k < SENSOR_COUNT; k++)
            f[k] = v;
        return f;
    endfunction

    task automatic run_traffic(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < count; b++) begin
                send_frame(random_frame());
                sent = sent + 1;
            end
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            else if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 10));
        end
        i_in_valid = 1'b0;
    endtask

    // The receiver stops while frames keep coming, so the input has to stall.
    task automatic flood_held_receiver();
        rx_hold_req = 1'b1;
        repeat (HOLD_BURST) send_frame(random_frame());
        i_in_valid = 1'b0;
    endtask

    initial begin
        t_readings f;
        logic [CFG_DATA_W-1:0] low;
        logic [CFG_DATA_W-1:0] offset;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_PROX_LOW;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_readings   = '0;
        win_low_now  = int'(PROX_LOW_RST);
        win_high_now = int'(PROX_HIGH_RST);
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words under the reset settings.
        send_frame(uniform_frame(16'h0000));
        send_frame(uniform_frame(16'h8000));
        send_frame(uniform_frame(16'h7FFF));
        f = {16'hFFFF, 16'd1, 16'd10001, 16'd10000, 16'd9999, 16'd101, 16'd100, 16'd99};
        send_frame(f);
        for (int k = 0; k < SENSOR_COUNT; k++) begin
            f    = uniform_frame(16'd150);
            f[k] = 16'd9999;
            send_frame(f);
        end
        f    = uniform_frame(16'd3000);
        f[2] = 16'd9000;
        f[5] = 16'd9000;
        send_frame(f);
        send_frame(uniform_frame(16'd500));
        // Distances of exactly the near limit and one below it.
        send_frame(uniform_frame(16'd155));
        send_frame(uniform_frame(16'd157));
        wait_drained();

        flood_held_receiver();
        run_traffic(250);
        wait_drained();

        // Every register at its widest value; upper data bits must be dropped.
        set_config('1, '1, '1, '1, '1);
        run_traffic(30);
        wait_drained();

        set_config(0, 32767, 255, 65535, 0);
        flood_held_receiver();
        run_traffic(150);
        wait_drained();

        set_config(0, 0, 0, 0, 0);
        run_traffic(30);
        wait_drained();

        write_reg(CFG_PROX_HIGH, 32767);
        write_reg(CFG_NEAR_LIMIT, 255);
        run_traffic(30);
        wait_drained();

        // Inverted window: nothing can be converted.
        set_config(20000, 50, 128, SCALE_RST, OFFSET_RST);
        run_traffic(30);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            low    = $urandom_range(0, 2000);
            offset = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom())
                                                 : CFG_DATA_W'($urandom_range(0, 64 << 16));
            set_config((CFG_DATA_W'($urandom()) & 24'hFF8000) | low,
                       (CFG_DATA_W'($urandom()) & 24'hFF8000)
                           | CFG_DATA_W'(low + $urandom_range(2, 32767 - low)),
                       $urandom(), $urandom(), offset);
            write_reg($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST), $urandom());
            run_traffic(80);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS ir_proximity_distance_nearest");
        else
            $display("FAIL ir_proximity_distance_nearest");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/ipdn_pkg.sv
design/ipdn_ctrl.sv
design/ipdn_lane.sv
design/ipdn_merge.sv
design/ir_proximity_distance_nearest.sv
design/ipdn_checker.sv
bench/ir_proximity_distance_nearest_checker.sv
bench/ir_proximity_distance_nearest_tb.sv
